### rtl/conv3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package conv3_pkg;

  // Payload widths fixed by the pixel and result formats.
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned PROD_W = 16;
  localparam int unsigned SUM_W  = 19;
  localparam int unsigned WROW_W = 24;

  // Configuration port geometry: three 24-bit registers on a 32-bit bus at 0x0, 0x4, 0x8.
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_ROW_TOP    = 2'd0;
  localparam logic [1:0] REG_ROW_MIDDLE = 2'd1;
  localparam logic [1:0] REG_ROW_BOTTOM = 2'd2;

  typedef logic signed [PIX_W-1:0]  pix_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [WROW_W-1:0]        wrow_t;

  // Tag that travels with a window through the product and output stages.
  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

endpackage

`default_nettype wire

### rtl/conv2d_3x3_int8_valid_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake                    Payload
// pixel      in         pixel_valid_i/pixel_stall_o  pixel_i (s8)
// conv       out        conv_valid_o/conv_stall_i    conv_sum_o (s19), frame_done_o
// config     in         psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// One pixel is accepted per cycle while pixel_stall_o is low; a window result then
// passes through line-buffer read, product register and sum register.
// Reset clears counters, window and weights; the line buffer RAM is not cleared.
// A stalled result holds only the stages behind it that are full; empty stages keep
// accepting pixels, so pixel_stall_o rises only while the whole pipeline is full.
module conv2d_3x3_int8_valid_core #(
  parameter int unsigned IMAGE_WIDTH  = 28,
  parameter int unsigned IMAGE_HEIGHT = 28
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           pixel_valid_i,
  output logic                                pixel_stall_o,
  input  wire conv3_pkg::pix_t                pixel_i,
  output logic                                conv_valid_o,
  input  wire logic                           conv_stall_i,
  output conv3_pkg::sum_t                     conv_sum_o,
  output logic                                frame_done_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [conv3_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [conv3_pkg::DATA_W-1:0]   pwdata,
  output logic      [conv3_pkg::DATA_W-1:0]   prdata,
  output logic                                pready
);

  localparam int unsigned CW = $clog2(IMAGE_WIDTH);
  localparam int unsigned RW = $clog2(IMAGE_HEIGHT);

  // Configuration registers.
  conv3_pkg::wrow_t wrow_q [3];
  logic [1:0]       reg_idx;
  logic             cfg_wr;

  // Raster counters and the line-read stage.
  logic [CW-1:0]   col_q;
  logic [RW-1:0]   row_q;
  logic            in_acc;
  logic            s1_valid_q;
  logic            s1_emit_q;
  logic            s1_last_q;
  conv3_pkg::pix_t s1_px_q;
  logic [CW-1:0]   s1_col_q;
  logic            s1_adv;
  logic [15:0]     line_rdata;

  conv3_pkg::pix_t  win_col [3];
  conv3_pkg::tag_t  s1_tag;
  conv3_pkg::tag_t  s2_tag;
  conv3_pkg::prod_t s2_prod [9];
  logic             s2_ready;
  logic             out_ready;

  // Register file: write on the access phase, combinational read.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        wrow_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        conv3_pkg::REG_ROW_TOP:    wrow_q[0] <= pwdata[conv3_pkg::WROW_W-1:0];
        conv3_pkg::REG_ROW_MIDDLE: wrow_q[1] <= pwdata[conv3_pkg::WROW_W-1:0];
        conv3_pkg::REG_ROW_BOTTOM: wrow_q[2] <= pwdata[conv3_pkg::WROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      conv3_pkg::REG_ROW_TOP:    prdata = conv3_pkg::DATA_W'(wrow_q[0]);
      conv3_pkg::REG_ROW_MIDDLE: prdata = conv3_pkg::DATA_W'(wrow_q[1]);
      conv3_pkg::REG_ROW_BOTTOM: prdata = conv3_pkg::DATA_W'(wrow_q[2]);
      default:                   prdata = '0;
    endcase
  end

  // Pipeline flow: a stage advances when the one after it can take the item.
  assign s1_adv        = s1_valid_q && s2_ready;
  assign pixel_stall_o = s1_valid_q && !s2_ready;
  assign in_acc        = pixel_valid_i && !pixel_stall_o;

  // Column and row counters wrap at the end of each line and frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (col_q == CW'(IMAGE_WIDTH - 1)) begin
        col_q <= '0;
        if (row_q == RW'(IMAGE_HEIGHT - 1)) begin
          row_q <= '0;
        end else begin
          row_q <= row_q + 1'b1;
        end
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // Line-read stage: holds the pixel while the two older rows come out of the RAM.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q   <= pixel_i;
      s1_col_q  <= col_q;
      s1_emit_q <= (row_q >= RW'(2)) && (col_q >= CW'(2));
      s1_last_q <= (row_q == RW'(IMAGE_HEIGHT - 1)) && (col_q == CW'(IMAGE_WIDTH - 1));
    end
  end

  // Each entry keeps {row r-2, row r-1} for one column. The write for a column
  // lands at least IMAGE_WIDTH-1 transfers before that column is read again.
  conv3_ram #(
    .WIDTH (16),
    .DEPTH (IMAGE_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i ({line_rdata[7:0], s1_px_q}),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (line_rdata)
  );

  assign win_col[0]   = conv3_pkg::pix_t'(line_rdata[15:8]);
  assign win_col[1]   = conv3_pkg::pix_t'(line_rdata[7:0]);
  assign win_col[2]   = s1_px_q;
  assign s1_tag.valid = s1_emit_q;
  assign s1_tag.last  = s1_last_q;

  conv3_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_adv),
    .col_i   (win_col),
    .wrow_i  (wrow_q),
    .tag_i   (s1_tag),
    .ready_i (out_ready),
    .prod_o  (s2_prod),
    .tag_o   (s2_tag),
    .ready_o (s2_ready)
  );

  conv3_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .prod_i  (s2_prod),
    .tag_i   (s2_tag),
    .stall_i (conv_stall_i),
    .ready_o (out_ready),
    .valid_o (conv_valid_o),
    .sum_o   (conv_sum_o),
    .last_o  (frame_done_o)
  );

endmodule

`default_nettype wire

### rtl/conv3_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module conv3_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/conv3_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module conv3_mac (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             shift_i,
  input  wire conv3_pkg::pix_t  col_i [3],
  input  wire conv3_pkg::wrow_t wrow_i [3],
  input  wire conv3_pkg::tag_t  tag_i,
  input  wire logic             ready_i,
  output conv3_pkg::prod_t      prod_o [9],
  output conv3_pkg::tag_t       tag_o,
  output logic                  ready_o
);

  conv3_pkg::pix_t  win_q [3][3];
  conv3_pkg::pix_t  win_d [3][3];
  conv3_pkg::prod_t prod_q [9];
  conv3_pkg::prod_t prod_d [9];
  conv3_pkg::tag_t  tag_q;
  conv3_pkg::tag_t  tag_d;

  // The window moves one column to the left and takes the new column on the right.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
      win_d[i][2] = col_i[i];
    end
  end

  // Nine independent 8x8 signed products of the shifted window.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i*3+j] = conv3_pkg::prod_t'(win_d[i][j]) *
                        conv3_pkg::prod_t'(conv3_pkg::pix_t'(wrow_i[i][8*j +: 8]));
      end
    end
  end

  // The product register is free when empty or when the output stage takes it.
  assign ready_o = !tag_q.valid || ready_i;

  always_comb begin
    tag_d = tag_q;
    if (ready_o) begin
      tag_d.valid = shift_i && tag_i.valid;
      tag_d.last  = tag_i.last;
    end
  end

  // Window state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (shift_i) begin
      win_q <= win_d;
    end
  end

  // Stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_d;
    end
  end

  // Product payload.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;
  assign tag_o  = tag_q;

endmodule

`default_nettype wire

### rtl/conv3_out.sv
`timescale 1ns / 1ps
`default_nettype none

module conv3_out (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire conv3_pkg::prod_t prod_i [9],
  input  wire conv3_pkg::tag_t  tag_i,
  input  wire logic             stall_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output conv3_pkg::sum_t       sum_o,
  output logic                  last_o
);

  conv3_pkg::sum_t sum_d;
  conv3_pkg::sum_t sum_q;
  logic            last_q;
  logic            valid_q;
  logic            load;

  // Adder chain over the nine products; the result always fits in 19 bits.
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < 9; k++) begin
      sum_d = sum_d + conv3_pkg::sum_t'(prod_i[k]);
    end
  end

  // The result register takes a new value when empty or when its transfer completes.
  assign ready_o = !valid_q || !stall_i;
  assign load    = ready_o && tag_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= tag_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sum_q  <= sum_d;
      last_q <= tag_i.last;
    end
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

### rtl/conv3_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module conv3_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         pixel_stall_o,
  input wire logic                         conv_valid_o,
  input wire logic                         conv_stall_i,
  input wire conv3_pkg::sum_t              conv_sum_o,
  input wire logic                         frame_done_o,
  input wire logic                         psel,
  input wire logic                         penable,
  input wire logic                         pwrite,
  input wire logic [conv3_pkg::ADDR_W-1:0] paddr,
  input wire logic [conv3_pkg::DATA_W-1:0] pwdata,
  input wire logic [conv3_pkg::DATA_W-1:0] prdata,
  input wire logic                         pready
);

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_valid_o && conv_stall_i |=>
      conv_valid_o && $stable(conv_sum_o) && $stable(frame_done_o))
    else $error("stalled result changed");

  // Input backpressure only comes from a stalled result with a full pipeline.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_stall_o |-> conv_valid_o && conv_stall_i)
    else $error("pixel stall without a stalled result");

  // A weight register reads back what was just written to it.
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready &&
      ((paddr[3:2] == conv3_pkg::REG_ROW_TOP) ||
       (paddr[3:2] == conv3_pkg::REG_ROW_MIDDLE) ||
       (paddr[3:2] == conv3_pkg::REG_ROW_BOTTOM)) ##1
      (paddr == $past(paddr)) |-> prdata[23:0] == $past(pwdata[23:0]))
    else $error("weight readback mismatch");

  // Weight registers are 24 bits wide and the port never waits.
  a_reg_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready && (prdata[31:24] == 8'd0))
    else $error("register port shape violated");

endmodule

bind conv2d_3x3_int8_valid_core conv3_checker u_conv3_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pixel_stall_o (pixel_stall_o),
  .conv_valid_o  (conv_valid_o),
  .conv_stall_i  (conv_stall_i),
  .conv_sum_o    (conv_sum_o),
  .frame_done_o  (frame_done_o),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);

`default_nettype wire
